[rtl/pwdt_pkg.sv]
// shared types, constants and helpers of the per-thread watchdog table
package pwdt_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ACT_W      = $clog2(ENTRIES + 1);
	localparam int ID_W       = 32;
	localparam int MAXC_W     = 16;
	localparam int OUT_ACT_W  = 5;
	localparam int OUT_W      = 40;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(ENTRIES - 1);
	localparam logic [MAXC_W-1:0]     MAXC_RST = MAXC_W'(10);

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// per-entry info handed to the scan unit
	typedef struct packed {
		logic             clr;
		logic             vld;
		req_t             op;
		logic [IDX_W-1:0] idx;
		logic             slot_vld;
	} scan_ctl_t;

	// what the scan found over the whole table
	typedef struct packed {
		logic             hit;
		logic [ID_W-1:0]  low_id;
		logic             match;
		logic [IDX_W-1:0] match_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      addr;
		logic [COUNT_BITS-1:0] data;
	} cnt_wr_t;

	function automatic logic [OUT_ACT_W-1:0] sat_active(input logic [ACT_W-1:0] n);
		logic [OUT_ACT_W-1:0] r;
		if (32'(n) > 32'd31) begin
			r = 5'd31;
		end else begin
			r = OUT_ACT_W'(n);
		end
		return r;
	endfunction

endpackage

[rtl/per_thread_watchdog_table.sv]
// top level of the per-thread watchdog table
// Watches up to ENTRIES thread ids, each with a tick counter held in ram.
// Input items arrive on s_tvalid/s_tready: s_tuser carries the request type
// (tick, start, stop, clear), s_tdata the thread id. Each item yields one
// result item on m_tvalid/m_tready with the trip flag, trip id, full flag,
// number of watched entries and an idle flag.
// Ticks, starts and stops walk the whole table through the id and count
// rams, one entry per cycle through the registered ram read port, and the
// result is loaded once the walk is done; a clear, or any item after a
// trip, skips the walk and goes straight to the finish state. The next
// item is taken the cycle after the result is loaded. The result sits in
// an output register; a stalled receiver holds it there and the block
// stops only once a second result is ready to load. The limit max_cycles
// is written on cfg_valid/cfg_ready (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the table, clears the trip and sets max_cycles to 10; no
// clearing pass is needed since slot valid bits are flops.
module per_thread_watchdog_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // thread_id[31:0]
	input  logic [1:0]                  s_tuser,  // req_type[1:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// tripped[0], trip_id[32:1], table_full[33], active_count[38:34], idle[39]
	output logic [pwdt_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [15:0]                 cfg_data
);

	pwdt_pkg::state_t                 state_q;
	pwdt_pkg::req_t                   op_q;
	logic [pwdt_pkg::ID_W-1:0]        id_q;
	logic [pwdt_pkg::IDX_W-1:0]       rd_idx_q;
	logic                             rd_done_q;
	logic                             vld_s1;
	logic [pwdt_pkg::IDX_W-1:0]       idx_s1;
	logic [pwdt_pkg::ENTRIES-1:0]     valid_q;
	logic [pwdt_pkg::ACT_W-1:0]       act_q;
	logic                             trip_q;
	logic [pwdt_pkg::ID_W-1:0]        trip_id_q;
	logic [pwdt_pkg::MAXC_W-1:0]      max_q;
	logic                             out_valid_q;
	logic [pwdt_pkg::OUT_W-1:0]       out_data_q;

	logic                             accept;
	logic                             issuing;
	logic                             fin_fire;
	pwdt_pkg::scan_ctl_t              ctl;
	pwdt_pkg::scan_res_t              res;
	pwdt_pkg::cnt_wr_t                scan_wr;
	logic [pwdt_pkg::ID_W-1:0]        id_rdata;
	logic [pwdt_pkg::COUNT_BITS-1:0]  cnt_rdata;

	logic                             id_we;
	logic                             cnt_we;
	logic [pwdt_pkg::IDX_W-1:0]       cnt_waddr;
	logic [pwdt_pkg::COUNT_BITS-1:0]  cnt_wdata;
	logic                             fin_start_we;

	logic [pwdt_pkg::ENTRIES-1:0]     valid_next;
	logic [pwdt_pkg::ACT_W-1:0]       act_next;
	logic                             trip_next;
	logic [pwdt_pkg::ID_W-1:0]        trip_id_next;
	logic                             full_next;

	assign s_tready  = (state_q == pwdt_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign issuing   = (state_q == pwdt_pkg::ST_SCAN) && !rd_done_q;
	assign fin_fire  = (state_q == pwdt_pkg::ST_FIN) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign ctl.clr      = accept;
	assign ctl.vld      = vld_s1;
	assign ctl.op       = op_q;
	assign ctl.idx      = idx_s1;
	assign ctl.slot_vld = valid_q[idx_s1];

	pwdt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.id_rdata   (id_rdata),
		.cnt_rdata  (cnt_rdata),
		.req_id     (id_q),
		.max_cycles (max_q),
		.res        (res),
		.cnt_wr     (scan_wr)
	);

	// start: reset an existing count or fill the lowest free slot
	assign fin_start_we = fin_fire && !trip_q && (op_q == pwdt_pkg::REQ_START)
		&& (res.match || res.free);
	assign id_we     = fin_start_we && !res.match;
	assign cnt_we    = fin_start_we || scan_wr.we;
	assign cnt_waddr = fin_start_we ? (res.match ? res.match_idx : res.free_idx)
		: scan_wr.addr;
	assign cnt_wdata = fin_start_we ? '0 : scan_wr.data;

	pwdt_ram #(
		.WIDTH (pwdt_pkg::ID_W),
		.DEPTH (pwdt_pkg::ENTRIES)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (res.free_idx),
		.wdata (id_q),
		.raddr (rd_idx_q),
		.rdata (id_rdata)
	);

	pwdt_ram #(
		.WIDTH (pwdt_pkg::COUNT_BITS),
		.DEPTH (pwdt_pkg::ENTRIES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (rd_idx_q),
		.rdata (cnt_rdata)
	);

	always_comb begin
		valid_next   = valid_q;
		act_next     = act_q;
		trip_next    = trip_q;
		trip_id_next = trip_id_q;
		full_next    = 1'b0;
		if (!trip_q) begin
			case (op_q)
				pwdt_pkg::REQ_TICK: begin
					if (res.hit) begin
						trip_next    = 1'b1;
						trip_id_next = res.low_id;
					end
				end
				pwdt_pkg::REQ_START: begin
					if (!res.match) begin
						if (res.free) begin
							valid_next[res.free_idx] = 1'b1;
							act_next = act_q + pwdt_pkg::ACT_W'(1);
						end else begin
							full_next = 1'b1;
						end
					end
				end
				pwdt_pkg::REQ_STOP: begin
					if (res.match) begin
						valid_next[res.match_idx] = 1'b0;
						act_next = act_q - pwdt_pkg::ACT_W'(1);
					end
				end
				default: begin
					valid_next = '0;
					act_next   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwdt_pkg::ST_IDLE;
			rd_idx_q    <= '0;
			rd_done_q   <= 1'b0;
			vld_s1      <= 1'b0;
			valid_q     <= '0;
			act_q       <= '0;
			trip_q      <= 1'b0;
			trip_id_q   <= '0;
			max_q       <= pwdt_pkg::MAXC_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			vld_s1 <= issuing;
			if (issuing) begin
				rd_idx_q <= rd_idx_q + pwdt_pkg::IDX_W'(1);
				if (rd_idx_q == pwdt_pkg::IDX_LAST) begin
					rd_done_q <= 1'b1;
				end
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pwdt_pkg::ST_IDLE: begin
					if (accept) begin
						rd_idx_q  <= '0;
						rd_done_q <= 1'b0;
						// clear and post-trip items need no walk
						if (trip_q || pwdt_pkg::req_t'(s_tuser) == pwdt_pkg::REQ_CLEAR) begin
							state_q <= pwdt_pkg::ST_FIN;
						end else begin
							state_q <= pwdt_pkg::ST_SCAN;
						end
					end
				end
				pwdt_pkg::ST_SCAN: begin
					if (vld_s1 && idx_s1 == pwdt_pkg::IDX_LAST) begin
						state_q <= pwdt_pkg::ST_FIN;
					end
				end
				pwdt_pkg::ST_FIN: begin
					if (fin_fire) begin
						state_q   <= pwdt_pkg::ST_IDLE;
						valid_q   <= valid_next;
						act_q     <= act_next;
						trip_q    <= trip_next;
						trip_id_q <= trip_id_next;
					end
				end
				default: begin
					state_q <= pwdt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			op_q <= pwdt_pkg::req_t'(s_tuser);
			id_q <= s_tdata;
		end
		if (fin_fire) begin
			out_data_q <= {(act_next == '0), pwdt_pkg::sat_active(act_next), full_next,
				trip_id_next, trip_next};
		end
	end

endmodule

[rtl/pwdt_ram.sv]
// generic simple dual-port ram with registered read
module pwdt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/pwdt_scan.sv]
// per-entry evaluation during a table walk: count update, trip search, id lookup
module pwdt_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pwdt_pkg::scan_ctl_t                 ctl,
	input  logic [pwdt_pkg::ID_W-1:0]           id_rdata,
	input  logic [pwdt_pkg::COUNT_BITS-1:0]     cnt_rdata,
	input  logic [pwdt_pkg::ID_W-1:0]           req_id,
	input  logic [pwdt_pkg::MAXC_W-1:0]         max_cycles,
	output pwdt_pkg::scan_res_t                 res,
	output pwdt_pkg::cnt_wr_t                   cnt_wr
);

	pwdt_pkg::scan_res_t           res_q;
	logic [pwdt_pkg::COUNT_BITS-1:0] cnt_inc;
	logic                          over;
	logic                          is_tick;

	assign is_tick = (ctl.op == pwdt_pkg::REQ_TICK);
	assign cnt_inc = (cnt_rdata == pwdt_pkg::CNT_MAX) ? cnt_rdata
		: cnt_rdata + pwdt_pkg::COUNT_BITS'(1);
	assign over    = (32'(cnt_inc) >= 32'(max_cycles));

	assign cnt_wr.we   = ctl.vld && ctl.slot_vld && is_tick;
	assign cnt_wr.addr = ctl.idx;
	assign cnt_wr.data = cnt_inc;

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.clr) begin
			res_q <= '0;
		end else if (ctl.vld) begin
			if (ctl.slot_vld) begin
				if (is_tick && over && (!res_q.hit || id_rdata < res_q.low_id)) begin
					res_q.hit    <= 1'b1;
					res_q.low_id <= id_rdata;
				end
				if (!is_tick && !res_q.match && id_rdata == req_id) begin
					res_q.match     <= 1'b1;
					res_q.match_idx <= ctl.idx;
				end
			end else if (!res_q.free) begin
				// lowest free slot
				res_q.free     <= 1'b1;
				res_q.free_idx <= ctl.idx;
			end
		end
	end

endmodule
